// ----- hdl/rfc_pkg.sv -----
// Package of the response frame checker: codes, protocol constants and the
// request type of the input channel. No dependencies.
package rfc_pkg;

	localparam logic [7:0] SYNC_FIRST   = 8'h47;
	localparam logic [7:0] SYNC_SECOND  = 8'h42;
	localparam logic [7:0] DEST_ID      = 8'h01;
	localparam logic [8:0] HEADER_EXTRA = 9'd6;
	localparam logic [8:0] MIN_FRAME    = 9'd10;
	localparam logic [8:0] POS_DEST     = 9'd2;
	localparam logic [8:0] POS_LEN      = 9'd5;
	localparam logic [8:0] POS_MSG_ID   = 9'd6;
	localparam logic [8:0] POS_PAYLOAD  = 9'd7;
	localparam logic [15:0] SYNC_SUM    = 16'({8'h00, SYNC_FIRST} + {8'h00, SYNC_SECOND});

	typedef enum logic [1:0] {
		CMD_BYTE    = 2'd0,
		CMD_START   = 2'd1,
		CMD_TIMEOUT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_END     = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ERROR   = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_FRAME = 2'd1
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
		logic [7:0] request_msg_id;
		logic [7:0] request_first_payload;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] frame_byte;
		logic [1:0] status;
		logic       last;
	} result_t;

endpackage

// ----- hdl/rfc_if.sv -----
// Channel interfaces of the response frame checker: input requests and
// result requests, each with valid, ready and payload. No dependencies.
interface rfc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic [7:0] request_msg_id;
	logic [7:0] request_first_payload;

	modport source (output valid, command, data_byte, request_msg_id,
		request_first_payload, input ready);
	modport sink (input valid, command, data_byte, request_msg_id,
		request_first_payload, output ready);
endinterface

interface rfc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] frame_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, kind, frame_byte, status, last, input ready);
	modport sink (input valid, kind, frame_byte, status, last, output ready);
endinterface

// ----- hdl/response_frame_checker.sv -----
// Top level of the response frame checker: sync hunt, frame parse and check.
// Depends on rfc_pkg and the interfaces in rfc_if.sv.
//
//   Channel   Direction   Modport   Carries
//   items     in          sink      command, data_byte, request ids
//   results   out         source    kind, frame_byte, status, last
//
// One request enters the input register per cycle while the result side is not
// stalled; it is processed from that register, and its result, if any, is written
// into the result register that drives the result port.
// Sustained rate is one request per cycle while results are taken.
// Reset clears all frame and request state; no clearing pass is needed.
// A stalled result holds the input register, which then holds the input side.
module response_frame_checker
	import rfc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rfc_item_if.sink     items,
	rfc_result_if.source results
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;
	logic    adv;

	phase_t     phase_q, phase_n;
	logic       saw_q, saw_n;
	logic [8:0] pos_q, pos_n;
	logic [8:0] total_q, total_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0] trailer_q, trailer_n;
	logic       match_q, match_n;
	logic       pending_q, pending_n;
	logic [7:0] exp_id_q, exp_id_n;
	logic [7:0] exp_pay_q, exp_pay_n;

	logic       res_hit;
	result_t    res_d;
	logic [9:0] p_plus1, p_plus2, tot_ext;
	logic       ends, ok;
	logic [7:0] b;

	assign adv           = !out_valid_q || results.ready;
	assign items.ready   = !valid_s1 || adv;
	assign results.valid = out_valid_q;
	assign results.kind       = res_q.kind;
	assign results.frame_byte = res_q.frame_byte;
	assign results.status     = res_q.status;
	assign results.last       = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= '{command: items.command, data_byte: items.data_byte,
				request_msg_id: items.request_msg_id,
				request_first_payload: items.request_first_payload};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_hit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			saw_q     <= 1'b0;
			pos_q     <= '0;
			total_q   <= '0;
			sum_q     <= '0;
			trailer_q <= '0;
			match_q   <= 1'b1;
			pending_q <= 1'b0;
			exp_id_q  <= '0;
			exp_pay_q <= '0;
		end else if (adv && valid_s1) begin
			phase_q   <= phase_n;
			saw_q     <= saw_n;
			pos_q     <= pos_n;
			total_q   <= total_n;
			sum_q     <= sum_n;
			trailer_q <= trailer_n;
			match_q   <= match_n;
			pending_q <= pending_n;
			exp_id_q  <= exp_id_n;
			exp_pay_q <= exp_pay_n;
		end
	end

	always_comb begin
		b         = item_s1.data_byte;
		phase_n   = phase_q;
		saw_n     = saw_q;
		pos_n     = pos_q;
		total_n   = total_q;
		sum_n     = sum_q;
		trailer_n = trailer_q;
		match_n   = match_q;
		pending_n = pending_q;
		exp_id_n  = exp_id_q;
		exp_pay_n = exp_pay_q;
		res_hit   = 1'b0;
		res_d     = '{kind: KIND_BYTE, frame_byte: b, status: ST_OK, last: 1'b0};
		p_plus1   = {1'b0, pos_q} + 10'd1;
		p_plus2   = {1'b0, pos_q} + 10'd2;
		tot_ext   = '0;
		ends      = 1'b0;
		ok        = 1'b0;
		case (item_s1.command)
			CMD_BYTE: begin
				if (phase_q != PH_FRAME) begin
					if (saw_q && b == SYNC_SECOND) begin
						phase_n   = PH_FRAME;
						saw_n     = 1'b0;
						pos_n     = POS_DEST;
						sum_n     = SYNC_SUM;
						total_n   = '0;
						trailer_n = '0;
						match_n   = 1'b1;
					end else begin
						saw_n = (b == SYNC_FIRST);
					end
				end else begin
					if (pos_q == POS_LEN) begin
						total_n = {1'b0, b} + HEADER_EXTRA;
					end
					if ((pos_q == POS_DEST && b != DEST_ID) ||
						(pos_q == POS_MSG_ID && b != exp_id_q) ||
						(pos_q == POS_PAYLOAD && b != exp_pay_q)) begin
						match_n = 1'b0;
					end
					tot_ext = {1'b0, total_n};
					if (pos_q <= POS_LEN || p_plus2 < tot_ext) begin
						sum_n = sum_q + {8'h00, b};
					end
					if (pos_q >= POS_MSG_ID && p_plus2 == tot_ext) begin
						trailer_n = b;
					end
					ends = (pos_q >= POS_LEN) && (p_plus1 == tot_ext);
					ok = (total_n >= MIN_FRAME) && match_n &&
						({trailer_n, b} == ~sum_n);
					if (!ends) begin
						pos_n = p_plus1[8:0];
						res_hit = pending_q;
					end else begin
						phase_n   = PH_HUNT;
						saw_n     = 1'b0;
						pos_n     = '0;
						total_n   = '0;
						sum_n     = '0;
						trailer_n = '0;
						match_n   = 1'b1;
						pending_n = 1'b0;
						res_hit   = pending_q;
						res_d     = '{kind: KIND_END, frame_byte: b,
							status: ok ? ST_OK : ST_ERROR, last: 1'b1};
					end
				end
			end
			CMD_START: begin
				pending_n = 1'b1;
				exp_id_n  = item_s1.request_msg_id;
				exp_pay_n = item_s1.request_first_payload;
			end
			CMD_TIMEOUT: begin
				if (pending_q) begin
					pending_n = 1'b0;
					res_hit   = 1'b1;
					res_d     = '{kind: KIND_TIMEOUT, frame_byte: 8'h00,
						status: ST_TIMEOUT, last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/rfc_checker.sv -----
// Port-level assertions for the response frame checker, bound to its top level.
// Depends on rfc_pkg.
module rfc_checker
	import rfc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] frame_byte,
	input logic [1:0] status,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result request dropped while stalled.");

	a_byte_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BYTE |-> !last && status == ST_OK)
		else $error("Passed byte carries a status or last flag.");

	a_timeout_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TIMEOUT |->
			last && status == ST_TIMEOUT && frame_byte == 8'h00)
		else $error("Malformed timeout report.");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("Result appeared without an accepted input request.");

endmodule

bind response_frame_checker rfc_checker u_rfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.kind       (results.kind),
	.frame_byte (results.frame_byte),
	.status     (results.status),
	.last       (results.last)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Testbench of response_frame_checker: sends framed byte streams, start and timeout requests
// with random idling on both channels and checks every result against a built-in model.
// Depends on rfc_pkg and the channel interfaces in hdl/rfc_if.sv.
module testbench;
	import rfc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 100;
	localparam int SHOWN_FAULTS = 10;

	typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_DEST, FLAW_ID, FLAW_PAYLOAD} flaw_t;
	typedef enum int {UPSET_NONE, UPSET_RESTART, UPSET_TIMEOUT, UPSET_CUT} upset_t;

	class reply_scoreboard;
		phase_t      phase;
		bit          saw_first;
		int          position;
		int          frame_len;
		logic [15:0] sum;
		logic [7:0]  trailer_high;
		bit          fields_ok;
		bit          armed;
		logic [7:0]  want_id;
		logic [7:0]  want_payload;
		result_t     awaited[$];
		int          faults;
		int          passed_bytes;
		int          good_frames;
		int          bad_frames;
		int          timeouts;

		function new();
			armed = 1'b0;
			want_id = 8'h00;
			want_payload = 8'h00;
			faults = 0;
			passed_bytes = 0;
			good_frames = 0;
			bad_frames = 0;
			timeouts = 0;
			restart_hunt();
		endfunction

		function void restart_hunt();
			phase = PH_HUNT;
			saw_first = 1'b0;
			position = 0;
			frame_len = 0;
			sum = 16'h0000;
			trailer_high = 8'h00;
			fields_ok = 1'b1;
		endfunction

		function void await_reply(kind_t k, logic [7:0] b, status_t s, logic l);
			result_t r;
			r.kind = k;
			r.frame_byte = b;
			r.status = s;
			r.last = l;
			awaited.push_back(r);
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function void predict_reply(item_t it);
			logic [7:0] b;
			int p;
			bit good;
			b = it.data_byte;
			case (it.command)
			CMD_BYTE: begin
				if (phase != PH_FRAME) begin
					if (saw_first && b == SYNC_SECOND) begin
						restart_hunt();
						phase = PH_FRAME;
						position = 2;
						sum = SYNC_SUM;
					end else begin
						saw_first = (b == SYNC_FIRST);
					end
				end else begin
					p = position;
					if (p == POS_LEN)
						frame_len = int'(b) + int'(HEADER_EXTRA);
					if (p == POS_DEST && b != DEST_ID)
						fields_ok = 1'b0;
					if (p == POS_MSG_ID && b != want_id)
						fields_ok = 1'b0;
					if (p == POS_PAYLOAD && b != want_payload)
						fields_ok = 1'b0;
					if (p <= int'(POS_LEN) || p + 2 < frame_len)
						sum = sum + b;
					if (p >= int'(POS_MSG_ID) && p + 2 == frame_len)
						trailer_high = b;
					if (p >= int'(POS_LEN) && p + 1 == frame_len) begin
						good = frame_len >= int'(MIN_FRAME) && fields_ok &&
							{trailer_high, b} == ~sum;
						restart_hunt();
						if (armed) begin
							armed = 1'b0;
							await_reply(KIND_END, b, good ? ST_OK : ST_ERROR, 1'b1);
						end
					end else begin
						position = p + 1;
						if (armed)
							await_reply(KIND_BYTE, b, ST_OK, 1'b0);
					end
				end
			end
			CMD_START: begin
				armed = 1'b1;
				want_id = it.request_msg_id;
				want_payload = it.request_first_payload;
			end
			CMD_TIMEOUT: begin
				if (armed) begin
					armed = 1'b0;
					await_reply(KIND_TIMEOUT, 8'h00, ST_TIMEOUT, 1'b1);
				end
			end
			default: begin
			end
			endcase
		endfunction

		function void match_reply(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				faults++;
				if (faults <= SHOWN_FAULTS)
					$display("Unexpected result: kind %0d byte %02h status %0d last %0d",
						got.kind, got.frame_byte, got.status, got.last);
				return;
			end
			want = awaited.pop_front();
			case (want.kind)
			KIND_BYTE: passed_bytes++;
			KIND_END: begin
				if (want.status == ST_OK)
					good_frames++;
				else
					bad_frames++;
			end
			default: timeouts++;
			endcase
			if (got.kind !== want.kind || got.frame_byte !== want.frame_byte ||
					got.status !== want.status || got.last !== want.last) begin
				faults++;
				if (faults <= SHOWN_FAULTS)
					$display("Result mismatch: expected kind %0d byte %02h status %0d last %0d, %s",
						want.kind, want.frame_byte, want.status, want.last,
						$sformatf("got kind %0d byte %02h status %0d last %0d",
						got.kind, got.frame_byte, got.status, got.last));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	rfc_item_if item_bus ();
	rfc_result_if result_bus ();
	reply_scoreboard book;
	int send_idle_pct = 35;
	int recv_idle_pct = 56;
	int items_sent = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	logic [7:0] frame_bytes[$];

	response_frame_checker uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_bus),
		.results(result_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// A requested hold-off keeps the result side stalled so that the checker backs up.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			book.match_reply('{result_bus.kind, result_bus.frame_byte, result_bus.status,
				result_bus.last});
	end

	function automatic logic [7:0] any_byte();
		case ($urandom_range(15))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	task automatic offer(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] id,
			input logic [7:0] pay);
		item_t it;
		it.command = cmd;
		it.data_byte = b;
		it.request_msg_id = id;
		it.request_first_payload = pay;
		while ($urandom_range(99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.command <= cmd;
		item_bus.data_byte <= b;
		item_bus.request_msg_id <= id;
		item_bus.request_first_payload <= pay;
		do
			@(posedge clk);
		while (!item_bus.ready);
		book.predict_reply(it);
		if (cmd != CMD_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		while (book.outstanding() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic void make_frame(input logic [7:0] len, id, pay, input flaw_t flaw);
		logic [15:0] byte_sum;
		logic [15:0] trailer;
		int n;
		n = int'(len) + 6;
		frame_bytes = {SYNC_FIRST, SYNC_SECOND, DEST_ID, any_byte(), any_byte(), len};
		if (flaw == FLAW_DEST)
			frame_bytes[2] ^= 8'd1 << $urandom_range(7);
		for (int i = 6; i < n - 2; i++)
			frame_bytes.push_back(i == 6 ? id : i == 7 ? pay : any_byte());
		if (flaw == FLAW_ID && frame_bytes.size() > 6)
			frame_bytes[6] ^= 8'd1 << $urandom_range(7);
		if (flaw == FLAW_PAYLOAD && frame_bytes.size() > 7)
			frame_bytes[7] ^= 8'd1 << $urandom_range(7);
		byte_sum = 16'h0000;
		foreach (frame_bytes[i])
			byte_sum += frame_bytes[i];
		trailer = ~byte_sum;
		if (flaw == FLAW_SUM)
			trailer ^= 16'd1 << $urandom_range(15);
		if (n - frame_bytes.size() == 2) begin
			frame_bytes.push_back(trailer[15:8]);
			frame_bytes.push_back(trailer[7:0]);
		end
		while (frame_bytes.size() < n)
			frame_bytes.push_back(any_byte());
	endfunction

	task automatic frame_exchange(input logic [7:0] len, input flaw_t flaw, input bit arm,
			input upset_t upset);
		logic [7:0] id;
		logic [7:0] pay;
		int cut_at;
		int n;
		id = any_byte();
		pay = any_byte();
		if (arm)
			offer(CMD_START, any_byte(), id, pay);
		make_frame(len, id, pay, flaw);
		cut_at = $urandom_range(2, frame_bytes.size() - 1);
		n = (upset == UPSET_CUT) ? cut_at : frame_bytes.size();
		for (int i = 0; i < n; i++) begin
			if (i == cut_at && upset == UPSET_RESTART)
				offer(CMD_START, any_byte(), $urandom_range(1) ? id : any_byte(), pay);
			if (i == cut_at && upset == UPSET_TIMEOUT)
				offer(CMD_TIMEOUT, any_byte(), any_byte(), any_byte());
			offer(CMD_BYTE, frame_bytes[i], any_byte(), any_byte());
		end
	endtask

	task automatic run_exchange();
		int pick;
		logic [7:0] len;
		flaw_t flaw;
		upset_t upset;
		pick = $urandom_range(99);
		if (pick < 12) begin
			repeat ($urandom_range(1, 4))
				offer(CMD_BYTE, any_byte(), any_byte(), any_byte());
			if ($urandom_range(9) == 0)
				offer(CMD_UNUSED, any_byte(), any_byte(), any_byte());
		end else if (pick < 18) begin
			offer(CMD_TIMEOUT, any_byte(), any_byte(), any_byte());
		end else if (pick < 22) begin
			offer(CMD_START, any_byte(), any_byte(), any_byte());
			offer(CMD_TIMEOUT, any_byte(), any_byte(), any_byte());
		end else begin
			pick = $urandom_range(99);
			len = pick < 3 ? 8'($urandom_range(25, 254)) :
				pick < 12 ? 8'($urandom_range(3)) : 8'($urandom_range(4, 24));
			flaw = $urandom_range(99) < 55 ? FLAW_NONE : flaw_t'($urandom_range(1, 4));
			upset = $urandom_range(99) < 80 ? UPSET_NONE : upset_t'($urandom_range(1, 3));
			frame_exchange(len, flaw, $urandom_range(99) < 80, upset);
		end
	endtask

	initial begin
		int goal;
		item_bus.valid = 1'b0;
		item_bus.command = CMD_BYTE;
		item_bus.data_byte = 8'h00;
		item_bus.request_msg_id = 8'h00;
		item_bus.request_first_payload = 8'h00;
		book = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Ignored command, timeout with nothing armed, shortest good frame, a frame
		// that ends on its length byte, and a timeout that closes an armed request.
		offer(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF);
		offer(CMD_TIMEOUT, 8'h00, 8'h00, 8'h00);
		frame_exchange(8'd4, FLAW_NONE, 1'b1, UPSET_NONE);
		frame_exchange(8'd0, FLAW_NONE, 1'b1, UPSET_NONE);
		offer(CMD_START, 8'h00, 8'hFF, 8'h00);
		offer(CMD_TIMEOUT, 8'hFF, 8'h00, 8'hFF);
		drain();

		for (int round = 0; round < 3; round++) begin
			send_idle_pct = round == 0 ? 35 : round == 1 ? 56 : 0;
			recv_idle_pct = round == 0 ? 56 : round == 1 ? 35 : 0;
			if (round == 2) begin
				hold_request = 1'b1;
				frame_exchange(8'd40, FLAW_NONE, 1'b1, UPSET_NONE);
				drain();
			end
			goal = items_sent + 480;
			frame_exchange(8'd255, round == 1 ? FLAW_SUM : FLAW_NONE, 1'b1, UPSET_NONE);
			while (items_sent < goal)
				run_exchange();
			drain();
		end
		repeat (8) @(posedge clk);

		$display("Covered %0d requests in %0d cycles under three idling patterns and a long stall.",
			items_sent, cycle_count);
		$display("Results: %0d passed bytes, %0d good frames, %0d bad frames, %0d timeouts.",
			book.passed_bytes, book.good_frames, book.bad_frames, book.timeouts);
		if (book.faults == 0 && book.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
